// File: hw/rtl/pcfl_pkg.sv
`default_nettype none

package pcfl_pkg;

  // Request codes carried by the func field of an input item.
  localparam logic [2:0] FUNC_INIT        = 3'd0;
  localparam logic [2:0] FUNC_ALLOC_PAGE  = 3'd1;
  localparam logic [2:0] FUNC_FREE_PAGE   = 3'd2;
  localparam logic [2:0] FUNC_ALLOC_CHUNK = 3'd3;
  localparam logic [2:0] FUNC_FREE_CHUNK  = 3'd4;

  // Status codes of a result item.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_TRUNC = 2'd3;

  // Configuration register indexes.
  localparam logic REG_RANGE_START = 1'b0;
  localparam logic REG_RANGE_END   = 1'b1;

  // Field widths fixed by the address map.
  localparam int ADDR_W  = 32;
  localparam int PAGE_W  = 20;
  localparam int CHUNK_W = 22;
  localparam int FB_W    = 26;
  localparam int CNT_W   = 21;

  // Outcome of the init range calculation.
  typedef struct packed {
    logic              done;
    logic              trunc;
    logic [PAGE_W-1:0] first_pg;
    logic [CNT_W-1:0]  count;
  } pcfl_init_t;

endpackage

`default_nettype wire

// File: hw/rtl/pcfl_ram.sv
`default_nettype none

module pcfl_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 4096
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic                                        re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: hw/rtl/pcfl_range.sv
`default_nettype none

module pcfl_range
  import pcfl_pkg::*;
#(
  parameter int MAX_PAGES = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [ADDR_W-1:0] range_start,
  input  wire logic [ADDR_W-1:0] range_end,
  output pcfl_init_t             res
);

  logic              v1_r;
  logic [CNT_W-1:0]  lo_pg_r;
  logic [PAGE_W-1:0] hi_pg_r;
  logic              done_r;
  logic              trunc_r;
  logic [PAGE_W-1:0] first_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  diff;

  // First stage: page numbers of the rounded bounds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      done_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      lo_pg_r <= {1'b0, range_start[ADDR_W-1:12]} +
                 CNT_W'(range_start[11:0] != 12'd0);
      hi_pg_r <= range_end[ADDR_W-1:12];
    end
  end

  assign diff = {1'b0, hi_pg_r} - lo_pg_r;

  // Second stage: page count, clamped to the stack depth.
  always_ff @(posedge clk) begin
    if (v1_r) begin
      first_r <= lo_pg_r[PAGE_W-1:0];
      if (lo_pg_r >= {1'b0, hi_pg_r}) begin
        count_r <= '0;
        trunc_r <= 1'b0;
      end else if (diff > CNT_W'(MAX_PAGES)) begin
        count_r <= CNT_W'(MAX_PAGES);
        trunc_r <= 1'b1;
      end else begin
        count_r <= diff;
        trunc_r <= 1'b0;
      end
    end
  end

  assign res.done     = done_r;
  assign res.trunc    = trunc_r;
  assign res.first_pg = first_r;
  assign res.count    = count_r;

endmodule

`default_nettype wire

// File: hw/rtl/page_and_chunk_free_list_allocator_core.sv
`default_nettype none

// Page and chunk allocator: two LIFO free stacks held in synchronous RAMs, one of
// 4 KiB page numbers (MAX_PAGES deep) and one of 1 KiB chunk numbers (4*MAX_PAGES
// deep), with their depths in counters. One request is handled at a time; a new
// item is taken as soon as the previous one has been handed to the output register,
// even if that result has not yet been taken. A free or an undefined request is
// decided in the execute state; an alloc starts one RAM read there and hands over
// the registered read data in its pop state; a chunk alloc that must split a page
// reads the page, then makes three chunk writes, one per cycle on the single write
// port, and then hands over the top chunk. Init runs the range calculation, then
// makes one page-stack write per cycle and finally hands over the result.
// The RAMs need no clearing after reset: only entries below a stack top are read.
module page_and_chunk_free_list_allocator_core
  import pcfl_pkg::*;
#(
  parameter int MAX_PAGES = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [ADDR_W-1:0] cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        in_func,
  input  wire logic [ADDR_W-1:0] in_address,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [ADDR_W-1:0]      out_granted_address,
  output logic [1:0]             out_status,
  output logic [FB_W-1:0]        out_free_bytes
);

  localparam int CH_DEPTH = 4 * MAX_PAGES;
  localparam int PA_W     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CA_W     = $clog2(CH_DEPTH);
  localparam int PT_W     = $clog2(MAX_PAGES + 1);
  localparam int CT_W     = $clog2(CH_DEPTH + 1);
  localparam int SUM_W    = PT_W + 13;

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_EXEC       = 4'd1;
  localparam logic [3:0] S_POP_P      = 4'd2;
  localparam logic [3:0] S_POP_C      = 4'd3;
  localparam logic [3:0] S_SPLIT_RD   = 4'd4;
  localparam logic [3:0] S_SPLIT_WR   = 4'd5;
  localparam logic [3:0] S_SPLIT_DONE = 4'd6;
  localparam logic [3:0] S_INIT_WAIT  = 4'd7;
  localparam logic [3:0] S_INIT_WALK  = 4'd8;

  logic [3:0]         state_r, state_nxt;
  logic [2:0]         func_r, func_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [PT_W-1:0]    page_top_r, page_top_nxt;
  logic [CT_W-1:0]    chunk_top_r, chunk_top_nxt;
  logic [PAGE_W-1:0]  split_pg_r, split_pg_nxt;
  logic [ADDR_W-1:0]  range_start_r, range_end_r;
  logic               out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [FB_W-1:0]    out_fb_r, out_fb_nxt;

  logic               out_free;
  logic               fin;
  logic [ADDR_W-1:0]  fin_addr;
  logic [1:0]         fin_status;
  logic [SUM_W-1:0]   fb_sum;
  logic               init_start;
  pcfl_init_t         init_res;

  logic               pg_we, pg_re;
  logic [PA_W-1:0]    pg_wa, pg_ra;
  logic [PAGE_W-1:0]  pg_wd, pg_rd;
  logic               ch_we, ch_re;
  logic [CA_W-1:0]    ch_wa, ch_ra;
  logic [CHUNK_W-1:0] ch_wd, ch_rd;

  // Stack storage.
  pcfl_ram #(.WIDTH(PAGE_W), .DEPTH(MAX_PAGES)) u_page_ram (
    .clk   (clk),
    .we    (pg_we),
    .waddr (pg_wa),
    .wdata (pg_wd),
    .re    (pg_re),
    .raddr (pg_ra),
    .rdata (pg_rd)
  );

  pcfl_ram #(.WIDTH(CHUNK_W), .DEPTH(CH_DEPTH)) u_chunk_ram (
    .clk   (clk),
    .we    (ch_we),
    .waddr (ch_wa),
    .wdata (ch_wd),
    .re    (ch_re),
    .raddr (ch_ra),
    .rdata (ch_rd)
  );

  // Init range calculation.
  pcfl_range #(.MAX_PAGES(MAX_PAGES)) u_range (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (init_start),
    .range_start (range_start_r),
    .range_end   (range_end_r),
    .res         (init_res)
  );

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_start_r <= '0;
      range_end_r   <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_RANGE_START) begin
        range_start_r <= cfg_data;
      end else begin
        range_end_r <= cfg_data;
      end
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // Request sequencer: read, modify and write back the stacks.
  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    addr_nxt      = addr_r;
    page_top_nxt  = page_top_r;
    chunk_top_nxt = chunk_top_r;
    split_pg_nxt  = split_pg_r;
    fin           = 1'b0;
    fin_addr      = '0;
    fin_status    = ST_OK;
    init_start    = 1'b0;
    pg_we         = 1'b0;
    pg_wa         = page_top_r[PA_W-1:0];
    pg_wd         = addr_r[ADDR_W-1:12];
    pg_re         = 1'b0;
    pg_ra         = PA_W'(page_top_r - PT_W'(1));
    ch_we         = 1'b0;
    ch_wa         = chunk_top_r[CA_W-1:0];
    ch_wd         = addr_r[ADDR_W-1:10];
    ch_re         = 1'b0;
    ch_ra         = CA_W'(chunk_top_r - CT_W'(1));

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_func;
          addr_nxt  = in_address;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (func_r)
          FUNC_INIT: begin
            page_top_nxt  = '0;
            chunk_top_nxt = '0;
            init_start    = 1'b1;
            state_nxt     = S_INIT_WAIT;
          end
          FUNC_ALLOC_PAGE: begin
            if (page_top_r != '0) begin
              pg_re     = 1'b1;
              state_nxt = S_POP_P;
            end else if (out_free) begin
              fin        = 1'b1;
              fin_status = ST_EMPTY;
            end
          end
          FUNC_FREE_PAGE: begin
            if (out_free) begin
              fin = 1'b1;
              if (page_top_r == PT_W'(MAX_PAGES)) begin
                fin_status = ST_FULL;
              end else begin
                pg_we        = 1'b1;
                page_top_nxt = page_top_r + PT_W'(1);
              end
            end
          end
          FUNC_ALLOC_CHUNK: begin
            if (chunk_top_r != '0) begin
              ch_re     = 1'b1;
              state_nxt = S_POP_C;
            end else if (page_top_r != '0) begin
              pg_re     = 1'b1;
              state_nxt = S_SPLIT_RD;
            end else if (out_free) begin
              fin        = 1'b1;
              fin_status = ST_EMPTY;
            end
          end
          FUNC_FREE_CHUNK: begin
            if (out_free) begin
              fin = 1'b1;
              if (chunk_top_r == CT_W'(CH_DEPTH)) begin
                fin_status = ST_FULL;
              end else begin
                ch_we         = 1'b1;
                chunk_top_nxt = chunk_top_r + CT_W'(1);
              end
            end
          end
          default: begin
            if (out_free) begin
              fin = 1'b1;
            end
          end
        endcase
      end
      S_POP_P: begin
        if (out_free) begin
          fin          = 1'b1;
          fin_addr     = {pg_rd, 12'd0};
          page_top_nxt = page_top_r - PT_W'(1);
        end
      end
      S_POP_C: begin
        if (out_free) begin
          fin           = 1'b1;
          fin_addr      = {ch_rd, 10'd0};
          chunk_top_nxt = chunk_top_r - CT_W'(1);
        end
      end
      S_SPLIT_RD: begin
        split_pg_nxt = pg_rd;
        page_top_nxt = page_top_r - PT_W'(1);
        state_nxt    = S_SPLIT_WR;
      end
      S_SPLIT_WR: begin
        // The three lower chunks go on the stack; the top one is granted afterwards.
        ch_we         = 1'b1;
        ch_wd         = {split_pg_r, chunk_top_r[1:0]};
        chunk_top_nxt = chunk_top_r + CT_W'(1);
        if (chunk_top_r == CT_W'(2)) begin
          state_nxt = S_SPLIT_DONE;
        end
      end
      S_SPLIT_DONE: begin
        if (out_free) begin
          fin      = 1'b1;
          fin_addr = {split_pg_r, 2'b11, 10'd0};
        end
      end
      S_INIT_WAIT: begin
        if (init_res.done) begin
          state_nxt = S_INIT_WALK;
        end
      end
      S_INIT_WALK: begin
        if (page_top_r != init_res.count[PT_W-1:0]) begin
          pg_we        = 1'b1;
          pg_wd        = init_res.first_pg + PAGE_W'(page_top_r);
          page_top_nxt = page_top_r + PT_W'(1);
        end else if (out_free) begin
          fin        = 1'b1;
          fin_status = init_res.trunc ? ST_TRUNC : ST_OK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt = S_IDLE;
    end
  end

  // Free byte count after the request.
  assign fb_sum = SUM_W'({page_top_nxt, 12'd0}) + SUM_W'({chunk_top_nxt, 10'd0});

  // Output register.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    out_fb_nxt     = out_fb_r;
    if (fin) begin
      out_valid_nxt  = 1'b1;
      out_addr_nxt   = fin_addr;
      out_status_nxt = fin_status;
      out_fb_nxt     = FB_W'(fb_sum);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      page_top_r  <= '0;
      chunk_top_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      page_top_r  <= page_top_nxt;
      chunk_top_r <= chunk_top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    addr_r       <= addr_nxt;
    split_pg_r   <= split_pg_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
    out_fb_r     <= out_fb_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_granted_address = out_addr_r;
  assign out_status          = out_status_r;
  assign out_free_bytes      = out_fb_r;

  // Stack depths never pass their capacities.
  assert property (@(posedge clk) disable iff (!rst_n)
    page_top_r <= PT_W'(MAX_PAGES))
    else $error("page stack depth beyond capacity");

  assert property (@(posedge clk) disable iff (!rst_n)
    chunk_top_r <= CT_W'(CH_DEPTH))
    else $error("chunk stack depth beyond capacity");

  // A page push never lands on a full page stack.
  assert property (@(posedge clk) disable iff (!rst_n)
    pg_we |-> (page_top_r != PT_W'(MAX_PAGES)))
    else $error("page write into a full stack");

  // Reads and writes of one stack never share a cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(ch_we && ch_re) && !(pg_we && pg_re))
    else $error("stack read and write in the same cycle");

  // A result that reports no memory grants nothing.
  assert property (@(posedge clk) disable iff (!rst_n)
    (fin && (fin_status == ST_EMPTY)) |=> (out_granted_address == '0))
    else $error("empty status with a granted address");

endmodule

`default_nettype wire
